@@ hw/rtl/bscu_pkg.sv @@
package bscu_pkg;

	// Channel words
	typedef struct packed {
		logic [15:0] raw_temp;
		logic [23:0] raw_press;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] temp_decicelsius;
		logic [17:0]        press_pa;
		logic               calc_error;
	} result_t;

	// Register file
	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	localparam logic [2:0] REG_OSS     = 3'd0;
	localparam logic [2:0] REG_AC1_AC3 = 3'd1;
	localparam logic [2:0] REG_AC4_AC6 = 3'd2;
	localparam logic [2:0] REG_B1_B2   = 3'd3;
	localparam logic [2:0] REG_MC_MD   = 3'd4;

	// Divider geometry: quotient bits resolved per pipeline stage
	localparam int DIV_STEPS = 2;

	// Temperature divider: |MC * 2^11| / |X1 + MD|
	localparam int DA_NW     = 27;
	localparam int DA_DW     = 18;
	localparam int DA_STAGES = (DA_NW + DIV_STEPS - 1) / DIV_STEPS;

	// Pressure divider: |B7 (or 2*B7)| / |B4|, low 32 quotient bits
	localparam int DB_NW     = 32;
	localparam int DB_DW     = 40;
	localparam int DB_STAGES = (DB_NW + DIV_STEPS - 1) / DIV_STEPS;

	// Register stages from accepted sample to result register
	localparam int PIPE_DEPTH = 13 + DA_STAGES + DB_STAGES;

	// Compensation constants
	localparam logic signed [28:0] C_B6_OFS   = 29'sd4000;
	localparam logic [16:0]        C_B7_SCALE = 17'd50000;
	localparam logic [11:0]        C_P_SQ     = 12'd3038;
	localparam logic signed [14:0] C_P_LIN    = -15'sd7357;
	localparam logic signed [44:0] C_P_OFS    = 45'sd3791;
	localparam logic signed [43:0] C_X3_OFS   = 44'sd32768;

	localparam logic signed [28:0] T_MAX_W = 29'sd32767;
	localparam logic signed [28:0] T_MIN_W = -29'sd32768;
	localparam logic signed [15:0] T_MAX   = 16'sh7fff;
	localparam logic signed [15:0] T_MIN   = 16'sh8000;

	localparam logic signed [31:0] P_POS_SAT = 32'sh7fffffff;
	localparam logic signed [31:0] P_NEG_SAT = 32'sh80000000;
	localparam logic signed [45:0] P_MAX_W   = 46'sd262143;
	localparam logic [17:0]        P_MAX     = 18'h3ffff;

	// Sideband that rides along each divider
	typedef struct packed {
		logic signed [17:0] x1;
		logic [23:0]        up;
		logic               neg;
		logic               err;
	} da_side_t;

	typedef struct packed {
		logic signed [15:0] t;
		logic               err;
		logic               neg;
		logic               dbl;
		logic               ovf;
	} db_side_t;

endpackage

@@ hw/rtl/baro_sensor_compensation_unit.sv @@
// Barometric temperature and pressure compensation, integer datasheet form.
// Sample channel: sample_valid / sample_stall with a word of raw_temp (16 bits)
// and raw_press (24 bits, three sensor bytes). Result channel: result_valid /
// result_stall with temp_decicelsius (0.1 degC), press_pa and calc_error.
// Calibration words and the oversampling setting are written over the APB
// port (64-bit registers at byte address 8*i); the user must write them only
// while no sample is in flight; the block itself does not enforce this. Two
// pipelined restoring dividers resolve two quotient bits per stage (14 stages
// for the temperature quotient, 16 for the pressure quotient), the rest are
// multiplier and adder stages. Throughput: one sample per unstalled cycle.
// All stages advance together; when the result register holds a word that the
// receiver stalls, the whole pipeline and sample_stall hold until it is taken.
// Reset clears every valid bit and zeroes the config registers (oversampling 0,
// calibration 0); a zero divisor sets calc_error and zeroes the outputs.
module baro_sensor_compensation_unit
	import bscu_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  sample_t           sample,
	output logic              result_valid,
	input  logic              result_stall,
	output result_t           result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	// Configuration registers
	logic [1:0]  oss_q;
	logic [47:0] cal_a_q;
	logic [47:0] cal_u_q;
	logic [31:0] cal_b_q;
	logic [31:0] cal_m_q;

	assign pready = 1'b1;

	// Write on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oss_q   <= '0;
			cal_a_q <= '0;
			cal_u_q <= '0;
			cal_b_q <= '0;
			cal_m_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[5:3])
				REG_OSS:     oss_q   <= pwdata[1:0];
				REG_AC1_AC3: cal_a_q <= pwdata[47:0];
				REG_AC4_AC6: cal_u_q <= pwdata[47:0];
				REG_B1_B2:   cal_b_q <= pwdata[31:0];
				REG_MC_MD:   cal_m_q <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (paddr[5:3])
			REG_OSS:     prdata = {62'b0, oss_q};
			REG_AC1_AC3: prdata = {16'b0, cal_a_q};
			REG_AC4_AC6: prdata = {16'b0, cal_u_q};
			REG_B1_B2:   prdata = {32'b0, cal_b_q};
			REG_MC_MD:   prdata = {32'b0, cal_m_q};
			default:     prdata = '0;
		endcase
	end

	// Calibration fields
	logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
	logic [15:0]        ac4, ac5, ac6;

	assign ac1 = cal_a_q[47:32];
	assign ac2 = cal_a_q[31:16];
	assign ac3 = cal_a_q[15:0];
	assign ac4 = cal_u_q[47:32];
	assign ac5 = cal_u_q[31:16];
	assign ac6 = cal_u_q[15:0];
	assign b1  = cal_b_q[31:16];
	assign b2  = cal_b_q[15:0];
	assign mc  = cal_m_q[31:16];
	assign md  = cal_m_q[15:0];

	// Pipeline advance and valid tracking
	logic                  adv;
	logic [PIPE_DEPTH-1:0] vld_q;

	assign adv          = !vld_q[PIPE_DEPTH-1] || !result_stall;
	assign sample_stall = !adv;
	assign result_valid = vld_q[PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], sample_valid};
		end
	end

	// Stage 1: X1 = ((UT - AC6) * AC5) >> 15, UP = raw >> (8 - OSS)
	logic signed [17:0] s1_diff;
	logic signed [34:0] s1_prod;
	logic [23:0]        s1_up;
	logic signed [17:0] x1_s1;
	logic [23:0]        up_s1;

	always_comb begin
		s1_diff = $signed({2'b00, sample.raw_temp}) - $signed({2'b00, ac6});
		s1_prod = s1_diff * $signed({1'b0, ac5});
		s1_up   = sample.raw_press >> (4'd8 - {2'b00, oss_q});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x1_s1 <= s1_prod[32:15];
			up_s1 <= s1_up;
		end
	end

	// Stage 2: form divisor X1 + MD and operand magnitudes
	logic signed [18:0] s2_d;
	logic signed [18:0] s2_dabs;
	logic [15:0]        s2_mcabs;

	always_comb begin
		s2_d     = x1_s1 + md;
		s2_dabs  = s2_d[18] ? -s2_d : s2_d;
		s2_mcabs = mc[15] ? (~mc + 16'd1) : mc;
	end

	// Temperature divider, two quotient bits per stage
	logic [DA_DW:0]   da_rem_s [DA_STAGES+1];
	logic [DA_NW-1:0] da_num_s [DA_STAGES+1];
	logic [DA_DW-1:0] da_dm_s  [DA_STAGES+1];
	da_side_t         da_sb_s  [DA_STAGES+1];
	logic [DA_DW:0]   da_rem_n [DA_STAGES];
	logic [DA_NW-1:0] da_num_n [DA_STAGES];

	always_comb begin
		logic [DA_DW:0]   rem;
		logic [DA_NW-1:0] num;
		logic [DA_DW:0]   trial;
		for (int g = 0; g < DA_STAGES; g++) begin
			rem   = da_rem_s[g];
			num   = da_num_s[g];
			trial = '0;
			for (int k = 0; k < DIV_STEPS; k++) begin
				if (g * DIV_STEPS + k < DA_NW) begin
					trial = {rem[DA_DW-1:0], num[DA_NW-1]};
					num   = {num[DA_NW-2:0], 1'b0};
					if (trial >= {1'b0, da_dm_s[g]}) begin
						trial  = trial - {1'b0, da_dm_s[g]};
						num[0] = 1'b1;
					end
					rem = trial;
				end
			end
			da_rem_n[g] = rem;
			da_num_n[g] = num;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			da_rem_s[0] <= '0;
			da_num_s[0] <= {s2_mcabs, 11'b0};
			da_dm_s[0]  <= s2_dabs[DA_DW-1:0];
			da_sb_s[0]  <= '{x1: x1_s1, up: up_s1, neg: mc[15] ^ s2_d[18],
				err: (s2_d == '0)};
			for (int g = 0; g < DA_STAGES; g++) begin
				da_rem_s[g+1] <= da_rem_n[g];
				da_num_s[g+1] <= da_num_n[g];
				da_dm_s[g+1]  <= da_dm_s[g];
				da_sb_s[g+1]  <= da_sb_s[g];
			end
		end
	end

	// Stage 4: B5, temperature, B6
	da_side_t           s4_sb;
	logic signed [27:0] s4_x2;
	logic signed [28:0] s4_b5;
	logic signed [28:0] s4_tr;
	logic signed [15:0] s4_t;
	logic signed [15:0] t_s4;
	logic signed [28:0] b6_s4;
	logic [23:0]        up_s4;
	logic               err_s4;

	always_comb begin
		s4_sb = da_sb_s[DA_STAGES];
		s4_x2 = s4_sb.neg ? -$signed({1'b0, da_num_s[DA_STAGES]})
			: $signed({1'b0, da_num_s[DA_STAGES]});
		s4_b5 = s4_sb.x1 + s4_x2;
		s4_tr = (s4_b5 + 29'sd8) >>> 4;
		if (s4_tr > T_MAX_W) begin
			s4_t = T_MAX;
		end else if (s4_tr < T_MIN_W) begin
			s4_t = T_MIN;
		end else begin
			s4_t = s4_tr[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s4   <= s4_t;
			b6_s4  <= s4_b5 - C_B6_OFS;
			up_s4  <= s4_sb.up;
			err_s4 <= s4_sb.err;
		end
	end

	// Stage 5: B6^2 >> 12, AC2*B6 >> 11, AC3*B6 >> 13
	logic signed [57:0] s5_sq;
	logic signed [44:0] s5_p2;
	logic signed [44:0] s5_p3;
	logic [41:0]        sq_s5;
	logic signed [32:0] x2a_s5;
	logic signed [30:0] x1b_s5;
	logic signed [15:0] t_s5;
	logic [23:0]        up_s5;
	logic               err_s5;

	always_comb begin
		s5_sq = b6_s4 * b6_s4;
		s5_p2 = ac2 * b6_s4;
		s5_p3 = ac3 * b6_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s5  <= s5_sq[53:12];
			x2a_s5 <= s5_p2[43:11];
			x1b_s5 <= s5_p3[43:13];
			t_s5   <= t_s4;
			up_s5  <= up_s4;
			err_s5 <= err_s4;
		end
	end

	// Stage 6: B2*sq >> 11, B1*sq >> 16
	logic signed [58:0] s6_pa;
	logic signed [58:0] s6_pb;
	logic signed [47:0] x1a_s6;
	logic signed [42:0] x2b_s6;
	logic signed [32:0] x2a_s6;
	logic signed [30:0] x1b_s6;
	logic signed [15:0] t_s6;
	logic [23:0]        up_s6;
	logic               err_s6;

	always_comb begin
		s6_pa = b2 * $signed({1'b0, sq_s5});
		s6_pb = b1 * $signed({1'b0, sq_s5});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x1a_s6 <= s6_pa[58:11];
			x2b_s6 <= s6_pb[58:16];
			x2a_s6 <= x2a_s5;
			x1b_s6 <= x1b_s5;
			t_s6   <= t_s5;
			up_s6  <= up_s5;
			err_s6 <= err_s5;
		end
	end

	// Stage 7: B3 with truncating divide by four, X3 for B4
	logic signed [48:0] s7_x3;
	logic signed [49:0] s7_v;
	logic signed [53:0] s7_w;
	logic signed [54:0] s7_r;
	logic signed [44:0] s7_y;
	logic signed [52:0] b3_s7;
	logic signed [42:0] x3b_s7;
	logic signed [15:0] t_s7;
	logic [23:0]        up_s7;
	logic               err_s7;

	always_comb begin
		s7_x3 = x1a_s6 + x2a_s6;
		s7_v  = $signed({{32{ac1[15]}}, ac1, 2'b00}) + s7_x3;
		s7_w  = (s7_v <<< oss_q) + 54'sd2;
		s7_r  = s7_w + (s7_w[53] ? 55'sd3 : 55'sd0);
		s7_y  = x1b_s6 + x2b_s6 + 45'sd2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b3_s7  <= s7_r[54:2];
			x3b_s7 <= s7_y[44:2];
			t_s7   <= t_s6;
			up_s7  <= up_s6;
			err_s7 <= err_s6;
		end
	end

	// Stage 8: B4 = AC4 * (X3 + 32768) >> 15, UP - B3
	logic signed [43:0] s8_y;
	logic signed [60:0] s8_p;
	logic signed [45:0] b4_s8;
	logic signed [53:0] upb_s8;
	logic signed [15:0] t_s8;
	logic               err_s8;

	always_comb begin
		s8_y = x3b_s7 + C_X3_OFS;
		s8_p = $signed({1'b0, ac4}) * s8_y;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b4_s8  <= s8_p[60:15];
			upb_s8 <= $signed({30'b0, up_s7}) - b3_s7;
			t_s8   <= t_s7;
			err_s8 <= err_s7;
		end
	end

	// Stage 9: B7 = (UP - B3) * (50000 >> OSS)
	logic [16:0]        s9_k;
	logic signed [71:0] s9_p;
	logic signed [63:0] b7_s9;
	logic signed [45:0] b4_s9;
	logic signed [15:0] t_s9;
	logic               err_s9;

	always_comb begin
		s9_k = C_B7_SCALE >> oss_q;
		s9_p = upb_s8 * $signed({1'b0, s9_k});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b7_s9  <= s9_p[63:0];
			b4_s9  <= b4_s8;
			t_s9   <= t_s8;
			err_s9 <= err_s8 | (b4_s8 == '0);
		end
	end

	// Stage 10: pick dividend form, magnitudes, overflow check
	logic        s10_small;
	logic [64:0] s10_n;
	logic [64:0] s10_nmag;
	logic [45:0] s10_dabs;
	logic        s10_ovf;

	always_comb begin
		s10_small = b7_s9 < 64'sh0000000080000000;
		s10_n     = s10_small ? {b7_s9, 1'b0} : {b7_s9[63], b7_s9};
		s10_nmag  = s10_n[64] ? (~s10_n + 65'd1) : s10_n;
		s10_dabs  = b4_s9[45] ? (~b4_s9 + 46'd1) : b4_s9;
		s10_ovf   = {8'b0, s10_nmag[63:32]} >= s10_dabs[DB_DW-1:0];
	end

	// Pressure divider, two quotient bits per stage
	logic [DB_DW:0]   db_rem_s [DB_STAGES+1];
	logic [DB_NW-1:0] db_num_s [DB_STAGES+1];
	logic [DB_DW-1:0] db_dm_s  [DB_STAGES+1];
	db_side_t         db_sb_s  [DB_STAGES+1];
	logic [DB_DW:0]   db_rem_n [DB_STAGES];
	logic [DB_NW-1:0] db_num_n [DB_STAGES];

	always_comb begin
		logic [DB_DW:0]   rem;
		logic [DB_NW-1:0] num;
		logic [DB_DW:0]   trial;
		for (int g = 0; g < DB_STAGES; g++) begin
			rem   = db_rem_s[g];
			num   = db_num_s[g];
			trial = '0;
			for (int k = 0; k < DIV_STEPS; k++) begin
				if (g * DIV_STEPS + k < DB_NW) begin
					trial = {rem[DB_DW-1:0], num[DB_NW-1]};
					num   = {num[DB_NW-2:0], 1'b0};
					if (trial >= {1'b0, db_dm_s[g]}) begin
						trial  = trial - {1'b0, db_dm_s[g]};
						num[0] = 1'b1;
					end
					rem = trial;
				end
			end
			db_rem_n[g] = rem;
			db_num_n[g] = num;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			db_rem_s[0] <= {9'b0, s10_nmag[63:32]};
			db_num_s[0] <= s10_nmag[31:0];
			db_dm_s[0]  <= s10_dabs[DB_DW-1:0];
			db_sb_s[0]  <= '{t: t_s9, err: err_s9, neg: s10_n[64] ^ b4_s9[45],
				dbl: !s10_small, ovf: s10_ovf};
			for (int g = 0; g < DB_STAGES; g++) begin
				db_rem_s[g+1] <= db_rem_n[g];
				db_num_s[g+1] <= db_num_n[g];
				db_dm_s[g+1]  <= db_dm_s[g];
				db_sb_s[g+1]  <= db_sb_s[g];
			end
		end
	end

	// Stage 11: apply doubling, sign and 32-bit saturation
	db_side_t           s11_sb;
	logic [33:0]        s11_mag;
	logic signed [31:0] s11_p;
	logic signed [31:0] p_s11;
	logic signed [15:0] t_s11;
	logic               err_s11;

	always_comb begin
		s11_sb  = db_sb_s[DB_STAGES];
		s11_mag = s11_sb.dbl ? {1'b0, db_num_s[DB_STAGES], 1'b0}
			: {2'b00, db_num_s[DB_STAGES]};
		if (s11_sb.ovf) begin
			s11_p = s11_sb.neg ? P_NEG_SAT : P_POS_SAT;
		end else if (s11_sb.neg) begin
			if (s11_mag > 34'h080000000) begin
				s11_p = P_NEG_SAT;
			end else begin
				s11_p = ~s11_mag[31:0] + 32'd1;
			end
		end else begin
			if (s11_mag > 34'h07fffffff) begin
				s11_p = P_POS_SAT;
			end else begin
				s11_p = s11_mag[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s11   <= s11_p;
			t_s11   <= s11_sb.t;
			err_s11 <= s11_sb.err;
		end
	end

	// Stage 12: (p >> 8)^2 and -7357 * p >> 16
	logic signed [23:0] s12_pa;
	logic signed [47:0] s12_sq;
	logic signed [46:0] s12_m;
	logic [46:0]        sq2_s12;
	logic signed [30:0] x2c_s12;
	logic signed [31:0] p_s12;
	logic signed [15:0] t_s12;
	logic               err_s12;

	always_comb begin
		s12_pa = p_s11[31:8];
		s12_sq = s12_pa * s12_pa;
		s12_m  = p_s11 * C_P_LIN;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq2_s12 <= s12_sq[46:0];
			x2c_s12 <= s12_m[46:16];
			p_s12   <= p_s11;
			t_s12   <= t_s11;
			err_s12 <= err_s11;
		end
	end

	// Stage 13: scale the square term
	logic [58:0]        s13_m;
	logic [42:0]        x1c_s13;
	logic signed [30:0] x2c_s13;
	logic signed [31:0] p_s13;
	logic signed [15:0] t_s13;
	logic               err_s13;

	always_comb begin
		s13_m = sq2_s12 * C_P_SQ;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x1c_s13 <= s13_m[58:16];
			x2c_s13 <= x2c_s12;
			p_s13   <= p_s12;
			t_s13   <= t_s12;
			err_s13 <= err_s12;
		end
	end

	// Stage 14: final correction, clamp, zero on error
	logic signed [44:0] s14_s;
	logic signed [40:0] s14_c;
	logic signed [45:0] s14_p;
	logic [17:0]        s14_pa;
	result_t            res_q;

	always_comb begin
		s14_s = $signed({1'b0, x1c_s13}) + x2c_s13 + C_P_OFS;
		s14_c = s14_s[44:4];
		s14_p = p_s13 + s14_c;
		if (s14_p[45]) begin
			s14_pa = '0;
		end else if (s14_p > P_MAX_W) begin
			s14_pa = P_MAX;
		end else begin
			s14_pa = s14_p[17:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.temp_decicelsius <= err_s13 ? 16'sd0 : t_s13;
			res_q.press_pa         <= err_s13 ? 18'd0 : s14_pa;
			res_q.calc_error       <= err_s13;
		end
	end

	assign result = res_q;

endmodule
